/* rtl/iss_pkg.sv */
// ============================================================================
// iss_pkg
// Shared constants and item types for the indexed stack store.
// ============================================================================
package iss_pkg;

    localparam int DEPTH  = 64;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = $clog2(DEPTH + 1);

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int POS_W    = 6;
    localparam int STATUS_W = 2;
    localparam int ECOUNT_W = 7;

    localparam logic [OPCODE_W-1:0] OP_PUSH   = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_REMOVE = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_READ   = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0]       opcode;
        logic signed [VALUE_W-1:0] value;
        logic [POS_W-1:0]          position;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0]       status;
        logic signed [VALUE_W-1:0] read_value;
        logic [ECOUNT_W-1:0]       entry_count;
    } t_out_item;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic                capture;
        logic [STATUS_W-1:0] status;
        logic                push;
        logic                rd_item;
        logic                rem_start;
        logic                shift_rd;
        logic                shift_wr;
        logic                count_dec;
        logic                load_out;
    } t_dp_cmd;

    // Conditions reported by the datapath.
    typedef struct packed {
        logic full;
        logic in_range;
        logic top_hit;
        logic shift_last;
    } t_dp_sts;

endpackage

/* rtl/iss_datapath.sv */
// ============================================================================
// iss_datapath
// Entry memory, entry count, shift pointer and the result register.
// ============================================================================
module iss_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  iss_pkg::t_in_item  i_in,
    input  iss_pkg::t_dp_cmd   i_cmd,
    output iss_pkg::t_dp_sts   o_sts,
    output iss_pkg::t_out_item o_out
);
    import iss_pkg::*;

    // Entries are stored bottom-up: slot 0 is the bottom of the stack.
    logic [VALUE_W-1:0] mem [DEPTH];

    logic [CNT_W-1:0]    r_count;
    logic [ADDR_W-1:0]   r_ptr;
    logic [OPCODE_W-1:0] r_op;
    logic [STATUS_W-1:0] r_status;
    logic [VALUE_W-1:0]  r_rdata;
    t_out_item           r_out;

    logic [CNT_W-1:0]  in_pos;
    logic [ADDR_W-1:0] item_slot;
    logic [ADDR_W-1:0] rd_addr;
    logic [ADDR_W-1:0] wr_addr;
    logic [VALUE_W-1:0] wr_data;
    logic              wr_en;
    logic              rd_en;

    assign in_pos    = CNT_W'(i_in.position);
    assign item_slot = ADDR_W'(r_count - CNT_W'(1) - in_pos);

    assign o_sts.full       = (r_count == CNT_W'(DEPTH));
    assign o_sts.in_range   = (in_pos < r_count);
    assign o_sts.top_hit    = (i_in.position == '0);
    assign o_sts.shift_last = ((CNT_W'(r_ptr) + CNT_W'(2)) == r_count);

    assign rd_en   = i_cmd.rd_item | i_cmd.shift_rd;
    assign rd_addr = i_cmd.shift_rd ? ADDR_W'(r_ptr + ADDR_W'(1)) : item_slot;
    assign wr_en   = i_cmd.push | i_cmd.shift_wr;
    assign wr_addr = i_cmd.shift_wr ? r_ptr : ADDR_W'(r_count);
    assign wr_data = i_cmd.shift_wr ? r_rdata : VALUE_W'(i_in.value);

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_cmd.push) begin
            r_count <= r_count + CNT_W'(1);
        end else if (i_cmd.count_dec) begin
            r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op     <= i_in.opcode;
            r_status <= i_cmd.status;
        end
        if (i_cmd.rem_start) begin
            r_ptr <= item_slot;
        end else if (i_cmd.shift_wr) begin
            r_ptr <= r_ptr + ADDR_W'(1);
        end
        if (i_cmd.load_out) begin
            r_out.status      <= r_status;
            r_out.read_value  <= (r_op == OP_READ && r_status == ST_OK) ? r_rdata : '0;
            r_out.entry_count <= ECOUNT_W'(r_count);
        end
    end

    assign o_out = r_out;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(DEPTH))
        else $error("entry count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.push |=> r_count == $past(r_count) + CNT_W'(1))
        else $error("push did not increment the count");

    a_shift_inside: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.shift_wr |-> (CNT_W'(r_ptr) + CNT_W'(1)) < r_count)
        else $error("shift write outside the held entries");

endmodule

/* rtl/iss_ctrl.sv */
// ============================================================================
// iss_ctrl
// Sequencer: decodes a request, runs the removal shift and hands off results.
// ============================================================================
module iss_ctrl (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    input  logic [iss_pkg::OPCODE_W-1:0]    i_opcode,
    output logic                            o_in_stall,
    input  logic                            i_out_stall,
    output logic                            o_out_valid,
    input  iss_pkg::t_dp_sts                i_sts,
    output iss_pkg::t_dp_cmd                o_cmd
);
    import iss_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_RESULT
    } t_state;

    t_state  r_state, n_state;
    logic    r_out_valid;
    t_dp_cmd cmd;

    always_comb begin
        cmd     = '0;
        n_state = r_state;
        cmd.status = ST_OK;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.capture = 1'b1;
                    n_state     = S_RESULT;
                    unique case (i_opcode)
                        OP_PUSH: begin
                            if (i_sts.full) begin
                                cmd.status = ST_FULL;
                            end else begin
                                cmd.push = 1'b1;
                            end
                        end
                        OP_REMOVE: begin
                            if (!i_sts.in_range) begin
                                cmd.status = ST_RANGE;
                            end else if (i_sts.top_hit) begin
                                cmd.count_dec = 1'b1;
                            end else begin
                                cmd.rem_start = 1'b1;
                                n_state       = S_SHIFT_RD;
                            end
                        end
                        OP_READ: begin
                            if (!i_sts.in_range) begin
                                cmd.status = ST_RANGE;
                            end else begin
                                cmd.rd_item = 1'b1;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_SHIFT_RD: begin
                cmd.shift_rd = 1'b1;
                n_state      = S_SHIFT_WR;
            end
            S_SHIFT_WR: begin
                cmd.shift_wr = 1'b1;
                if (i_sts.shift_last) begin
                    cmd.count_dec = 1'b1;
                    n_state       = S_RESULT;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_RESULT: begin
                if (!r_out_valid || !i_out_stall) begin
                    cmd.load_out = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

endmodule

/* rtl/indexed_stack_store.sv */
// ============================================================================
// indexed_stack_store
// Stack of signed 32-bit entries with read and removal at any position.
// ============================================================================
// Push, read and failed requests go from acceptance to the result state. A
// removal at position p first moves each of the p entries above the gap with
// one read and one write of the single-port-pair entry memory.
// One request is in flight at a time; the result register frees the input.
// Reset is synchronous and clears the entry count and the control state.
module indexed_stack_store (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  iss_pkg::t_in_item  i_in,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output iss_pkg::t_out_item o_out
);
    import iss_pkg::*;

    t_dp_cmd cmd;
    t_dp_sts sts;

    iss_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_opcode    (i_in.opcode),
        .o_in_stall  (o_in_stall),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    iss_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_cmd   (cmd),
        .o_sts   (sts),
        .o_out   (o_out)
    );

endmodule
